[rtl/core/dpec_pkg.sv]
package dpec_pkg;

    // Fixed-point format of positions, velocities, radii and masses.
    localparam int FRAC_BITS = 16;

    // Mass factor width: the factor reaches 2.0, so two integer bits.
    localparam int FW        = FRAC_BITS + 2;
    // Numerator width of the mass factor division: (2 * m) << FRAC_BITS.
    localparam int FN_W      = 32 + FRAC_BITS;

    // Magnitude of the dot product and width of the squared distance.
    localparam int DM_W      = 66;
    localparam int DM_CW     = DM_W / 3;
    // Product of dot magnitude and mass factor.
    localparam int TW        = DM_W + FW;
    localparam int TC_W      = (TW + 3) / 4;
    // Quotient bits kept; larger changes saturate the velocity anyway.
    localparam int QW        = 33;
    localparam int NUM_W     = TW + QW;
    localparam int DEN_W     = DM_W + FRAC_BITS;

    // Latencies of the divider pipelines and alignment lengths.
    localparam int FDIV_LAT  = FW + 1;
    localparam int QDIV_LAT  = QW + 1;
    localparam int HOLD_LEN  = FDIV_LAT - 3;
    localparam int VLD_LEN   = FDIV_LAT + QDIV_LAT + 6;

    // Per-item values carried through the front stages.
    typedef struct packed {
        logic [3:0][31:0] vel;
        logic [32:0]      ux;
        logic [32:0]      uy;
        logic             sx;
        logic             sy;
        logic             msum_nz;
    } t_carry;

    // Per-item values carried while the mass factors are computed.
    typedef struct packed {
        logic [3:0][31:0] vel;
        logic [32:0]      ux;
        logic [32:0]      uy;
        logic             sx;
        logic             sy;
        logic             dotneg;
        logic             apply;
        logic [DM_W-1:0]  dotmag;
        logic [DM_W-1:0]  dist2;
    } t_mid;

    // Per-item values carried alongside the quotient dividers.
    typedef struct packed {
        logic [3:0][31:0] vel;
        logic             sx;
        logic             sy;
        logic             dotneg;
        logic             apply;
    } t_fin;

endpackage

[rtl/core/dpec_fdiv.sv]
module dpec_fdiv import dpec_pkg::*; (
    input  logic          i_clk,
    input  logic [30:0]   i_ma,
    input  logic [30:0]   i_mb,
    output logic [FW-1:0] o_fa,
    output logic [FW-1:0] o_fb
);

    // Restoring division of 2*m*2^FRAC_BITS by the mass sum, one quotient
    // bit per stage, two lanes sharing the divisor.
    logic [31:0]   r_den   [FW+1];
    logic [31:0]   r_rem_a [FW+1];
    logic [31:0]   r_rem_b [FW+1];
    logic [FW-1:0] r_low_a [FW+1];
    logic [FW-1:0] r_low_b [FW+1];
    logic [FW-1:0] r_q_a   [FW+1];
    logic [FW-1:0] r_q_b   [FW+1];

    logic [31:0]   n_rem_a [FW];
    logic [31:0]   n_rem_b [FW];
    logic          n_ge_a  [FW];
    logic          n_ge_b  [FW];

    logic [FN_W-1:0] num_a;
    logic [FN_W-1:0] num_b;

    assign num_a = FN_W'({i_ma, 1'b0}) << FRAC_BITS;
    assign num_b = FN_W'({i_mb, 1'b0}) << FRAC_BITS;

    // One trial subtraction per stage and lane.
    always_comb begin
        logic [32:0] ta;
        logic [32:0] tb;
        for (int s = 0; s < FW; s++) begin
            ta = {r_rem_a[s], r_low_a[s][FW-1]};
            tb = {r_rem_b[s], r_low_b[s][FW-1]};
            n_ge_a[s]  = ta >= {1'b0, r_den[s]};
            n_ge_b[s]  = tb >= {1'b0, r_den[s]};
            n_rem_a[s] = n_ge_a[s] ? 32'(ta - {1'b0, r_den[s]}) : ta[31:0];
            n_rem_b[s] = n_ge_b[s] ? 32'(tb - {1'b0, r_den[s]}) : tb[31:0];
        end
    end

    // Stage registers: setup first, then one stage per quotient bit.
    always_ff @(posedge i_clk) begin
        r_den[0]   <= 32'(i_ma) + 32'(i_mb);
        r_rem_a[0] <= 32'(num_a >> FW);
        r_rem_b[0] <= 32'(num_b >> FW);
        r_low_a[0] <= num_a[FW-1:0];
        r_low_b[0] <= num_b[FW-1:0];
        r_q_a[0]   <= '0;
        r_q_b[0]   <= '0;
        for (int s = 0; s < FW; s++) begin
            r_den[s+1]   <= r_den[s];
            r_rem_a[s+1] <= n_rem_a[s];
            r_rem_b[s+1] <= n_rem_b[s];
            r_low_a[s+1] <= r_low_a[s] << 1;
            r_low_b[s+1] <= r_low_b[s] << 1;
            r_q_a[s+1]   <= {r_q_a[s][FW-2:0], n_ge_a[s]};
            r_q_b[s+1]   <= {r_q_b[s][FW-2:0], n_ge_b[s]};
        end
    end

    assign o_fa = r_q_a[FW];
    assign o_fb = r_q_b[FW];

endmodule

[rtl/core/dpec_qdiv.sv]
module dpec_qdiv import dpec_pkg::*; (
    input  logic              i_clk,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic [QW:0]       o_q
);

    // Restoring division with a clamp: a quotient of 2^QW or more reads
    // as exactly 2^QW.
    logic [DEN_W-1:0] r_den [QW+1];
    logic [DEN_W-1:0] r_rem [QW+1];
    logic [QW-1:0]    r_low [QW+1];
    logic [QW-1:0]    r_q   [QW+1];
    logic             r_ovf [QW+1];

    logic [DEN_W-1:0] n_rem [QW];
    logic             n_ge  [QW];

    logic [TW-1:0]    num_hi;

    assign num_hi = i_num[NUM_W-1:QW];

    // One trial subtraction per stage.
    always_comb begin
        logic [DEN_W:0] t;
        for (int s = 0; s < QW; s++) begin
            t        = {r_rem[s], r_low[s][QW-1]};
            n_ge[s]  = t >= {1'b0, r_den[s]};
            n_rem[s] = n_ge[s] ? DEN_W'(t - {1'b0, r_den[s]}) : t[DEN_W-1:0];
        end
    end

    // Overflow check on entry, then one stage per quotient bit.
    always_ff @(posedge i_clk) begin
        r_den[0] <= i_den;
        r_rem[0] <= DEN_W'(num_hi);
        r_low[0] <= i_num[QW-1:0];
        r_q[0]   <= '0;
        r_ovf[0] <= num_hi >= TW'(i_den);
        for (int s = 0; s < QW; s++) begin
            r_den[s+1] <= r_den[s];
            r_rem[s+1] <= n_rem[s];
            r_low[s+1] <= r_low[s] << 1;
            r_q[s+1]   <= {r_q[s][QW-2:0], n_ge[s]};
            r_ovf[s+1] <= r_ovf[s];
        end
    end

    assign o_q = r_ovf[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, r_q[QW]};

endmodule

[rtl/core/disk_pair_elastic_collision_top.sv]
// Elastic collision of a pair of disks, fully pipelined.
// Throughput: one pair per clock cycle; busy is never raised.
// The result path runs through the mass factor divider (19 stages) and the
// impulse divider (34 stages).
// Reset (synchronous, active low) clears only the valid pipeline; results
// cannot be stalled by the receiver.
module disk_pair_elastic_collision_top import dpec_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_a_pos_x,
    input  logic signed [31:0] i_a_pos_y,
    input  logic signed [31:0] i_a_vel_x,
    input  logic signed [31:0] i_a_vel_y,
    input  logic [30:0]        i_a_radius,
    input  logic [30:0]        i_a_mass,
    input  logic signed [31:0] i_b_pos_x,
    input  logic signed [31:0] i_b_pos_y,
    input  logic signed [31:0] i_b_vel_x,
    input  logic signed [31:0] i_b_vel_y,
    input  logic [30:0]        i_b_radius,
    input  logic [30:0]        i_b_mass,
    output logic               o_valid,
    output logic signed [31:0] o_a_new_vel_x,
    output logic signed [31:0] o_a_new_vel_y,
    output logic signed [31:0] o_b_new_vel_x,
    output logic signed [31:0] o_b_new_vel_y,
    output logic               o_collided
);

    // Valid bits travel alongside the data.
    logic [VLD_LEN-1:0] r_vld;

    // Stage 1: input registers.
    logic signed [31:0] r1_apx, r1_apy, r1_bpx, r1_bpy;
    logic [3:0][31:0]   r1_vel;
    logic [30:0]        r1_ra, r1_rb, r1_ma, r1_mb;

    // Stage 2: offsets and sums.
    t_carry             r2_c;
    logic signed [32:0] r2_dx, r2_dy, r2_dvx, r2_dvy;
    logic [31:0]        r2_rsum;

    // Stage 3: products.
    t_carry             r3_c;
    logic [65:0]        r3_ux2, r3_uy2;
    logic [63:0]        r3_rsq;
    logic signed [65:0] r3_pdx, r3_pdy;

    // Stage 4: squared distance and dot product.
    t_carry             r4_c;
    logic [DM_W-1:0]    r4_dist2;
    logic [63:0]        r4_rsq;
    logic signed [66:0] r4_dot;

    // Decision and hold line aligned with the mass factors.
    t_mid               n_mid;
    t_mid               r_hold [HOLD_LEN];
    logic [FW-1:0]      fa, fb;

    // Numerator build stages.
    t_mid               r_m1, r_m2, r_m3, r_m4;
    logic [DM_CW+FW-1:0] r_pa [3];
    logic [DM_CW+FW-1:0] r_pb [3];
    logic [TW-1:0]      r_ta, r_tb;
    logic [TC_W+32:0]   r_pp [4][4];
    logic [NUM_W-1:0]   r_num [4];
    logic [DEN_W-1:0]   r_den;

    logic [4*TC_W-1:0]  tpad_a, tpad_b;
    logic [NUM_W-1:0]   n_num [4];

    // Quotient side line and outputs.
    t_fin               r_qs [QDIV_LAT];
    logic [QW:0]        q [4];
    logic [3:0][31:0]   n_vel;

    assign busy = 1'b0;

    // Valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[VLD_LEN-2:0], start};
        end
    end

    // Stage 1: register the accepted transfer.
    always_ff @(posedge i_clk) begin
        r1_apx <= i_a_pos_x;
        r1_apy <= i_a_pos_y;
        r1_bpx <= i_b_pos_x;
        r1_bpy <= i_b_pos_y;
        r1_vel <= {i_b_vel_y, i_b_vel_x, i_a_vel_y, i_a_vel_x};
        r1_ra  <= i_a_radius;
        r1_rb  <= i_b_radius;
        r1_ma  <= i_a_mass;
        r1_mb  <= i_b_mass;
    end

    // Stage 2: offsets, relative velocity, radius sum.
    always_ff @(posedge i_clk) begin
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        dx = 33'(r1_apx) - 33'(r1_bpx);
        dy = 33'(r1_apy) - 33'(r1_bpy);
        r2_dx      <= dx;
        r2_dy      <= dy;
        r2_dvx     <= 33'($signed(r1_vel[0])) - 33'($signed(r1_vel[2]));
        r2_dvy     <= 33'($signed(r1_vel[1])) - 33'($signed(r1_vel[3]));
        r2_rsum    <= 32'(r1_ra) + 32'(r1_rb);
        r2_c.vel   <= r1_vel;
        r2_c.sx    <= dx[32];
        r2_c.sy    <= dy[32];
        r2_c.ux    <= dx[32] ? 33'(~dx + 33'sd1) : 33'(dx);
        r2_c.uy    <= dy[32] ? 33'(~dy + 33'sd1) : 33'(dy);
        r2_c.msum_nz <= (r1_ma != '0) || (r1_mb != '0);
    end

    // Stage 3: squares and dot product terms.
    always_ff @(posedge i_clk) begin
        r3_c   <= r2_c;
        r3_ux2 <= 66'(r2_c.ux) * 66'(r2_c.ux);
        r3_uy2 <= 66'(r2_c.uy) * 66'(r2_c.uy);
        r3_rsq <= 64'(r2_rsum) * 64'(r2_rsum);
        r3_pdx <= 66'(r2_dvx) * 66'(r2_dx);
        r3_pdy <= 66'(r2_dvy) * 66'(r2_dy);
    end

    // Stage 4: sums.
    always_ff @(posedge i_clk) begin
        r4_c     <= r3_c;
        r4_dist2 <= r3_ux2 + r3_uy2;
        r4_rsq   <= r3_rsq;
        r4_dot   <= 67'(r3_pdx) + 67'(r3_pdy);
    end

    // Collision decision: touching, approaching, nondegenerate.
    always_comb begin
        logic [66:0] dmag;
        dmag         = r4_dot[66] ? 67'(~r4_dot + 67'sd1) : 67'(r4_dot);
        n_mid.vel    = r4_c.vel;
        n_mid.ux     = r4_c.ux;
        n_mid.uy     = r4_c.uy;
        n_mid.sx     = r4_c.sx;
        n_mid.sy     = r4_c.sy;
        n_mid.dotneg = r4_dot[66];
        n_mid.apply  = (r4_dist2 <= DM_W'(r4_rsq))
                       && (r4_dot[66] || (r4_dot == '0))
                       && (r4_dist2 != '0) && r4_c.msum_nz;
        n_mid.dotmag = dmag[DM_W-1:0];
        n_mid.dist2  = r4_dist2;
    end

    // Hold line until the mass factors are ready.
    always_ff @(posedge i_clk) begin
        r_hold[0] <= n_mid;
        for (int j = 1; j < HOLD_LEN; j++) begin
            r_hold[j] <= r_hold[j-1];
        end
    end

    dpec_fdiv u_fdiv (
        .i_clk (i_clk),
        .i_ma  (r1_ma),
        .i_mb  (r1_mb),
        .o_fa  (fa),
        .o_fb  (fb)
    );

    // M1: dot magnitude times mass factors, as partial products.
    always_ff @(posedge i_clk) begin
        r_m1 <= r_hold[HOLD_LEN-1];
        for (int k = 0; k < 3; k++) begin
            r_pa[k] <= (DM_CW+FW)'(r_hold[HOLD_LEN-1].dotmag[k*DM_CW +: DM_CW])
                       * (DM_CW+FW)'(fa);
            r_pb[k] <= (DM_CW+FW)'(r_hold[HOLD_LEN-1].dotmag[k*DM_CW +: DM_CW])
                       * (DM_CW+FW)'(fb);
        end
    end

    // M2: add the partial products.
    always_ff @(posedge i_clk) begin
        r_m2 <= r_m1;
        r_ta <= TW'(r_pa[0]) + (TW'(r_pa[1]) << DM_CW) + (TW'(r_pa[2]) << (2 * DM_CW));
        r_tb <= TW'(r_pb[0]) + (TW'(r_pb[1]) << DM_CW) + (TW'(r_pb[2]) << (2 * DM_CW));
    end

    assign tpad_a = (4*TC_W)'(r_ta);
    assign tpad_b = (4*TC_W)'(r_tb);

    // M3: times the offset components. Disk a uses fb, disk b uses fa.
    always_ff @(posedge i_clk) begin
        r_m3 <= r_m2;
        for (int k = 0; k < 4; k++) begin
            r_pp[0][k] <= (TC_W+33)'(tpad_b[k*TC_W +: TC_W]) * (TC_W+33)'(r_m2.ux);
            r_pp[1][k] <= (TC_W+33)'(tpad_b[k*TC_W +: TC_W]) * (TC_W+33)'(r_m2.uy);
            r_pp[2][k] <= (TC_W+33)'(tpad_a[k*TC_W +: TC_W]) * (TC_W+33)'(r_m2.ux);
            r_pp[3][k] <= (TC_W+33)'(tpad_a[k*TC_W +: TC_W]) * (TC_W+33)'(r_m2.uy);
        end
    end

    // M4: final numerators and the shifted squared distance.
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            n_num[l] = '0;
            for (int k = 0; k < 4; k++) begin
                n_num[l] = n_num[l] + (NUM_W'(r_pp[l][k]) << (k * TC_W));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m4 <= r_m3;
        r_den <= DEN_W'(r_m3.dist2) << FRAC_BITS;
        for (int l = 0; l < 4; l++) begin
            r_num[l] <= n_num[l];
        end
    end

    // Four impulse dividers sharing one divisor.
    for (genvar l = 0; l < 4; l++) begin : g_qdiv
        dpec_qdiv u_qdiv (
            .i_clk (i_clk),
            .i_num (r_num[l]),
            .i_den (r_den),
            .o_q   (q[l])
        );
    end

    // Side line alongside the dividers.
    always_ff @(posedge i_clk) begin
        r_qs[0].vel    <= r_m4.vel;
        r_qs[0].sx     <= r_m4.sx;
        r_qs[0].sy     <= r_m4.sy;
        r_qs[0].dotneg <= r_m4.dotneg;
        r_qs[0].apply  <= r_m4.apply;
        for (int j = 1; j < QDIV_LAT; j++) begin
            r_qs[j] <= r_qs[j-1];
        end
    end

    // Apply the signed change and saturate to 32 bits.
    always_comb begin
        logic              neg;
        logic              add;
        logic signed [35:0] v;
        logic signed [35:0] m;
        logic signed [35:0] s;
        for (int l = 0; l < 4; l++) begin
            neg = (((l % 2) == 0) ? r_qs[QDIV_LAT-1].sx : r_qs[QDIV_LAT-1].sy)
                  != r_qs[QDIV_LAT-1].dotneg;
            add = neg ^ (l >= 2);
            v   = 36'($signed(r_qs[QDIV_LAT-1].vel[l]));
            m   = $signed(36'(q[l]));
            s   = add ? v + m : v - m;
            if (!r_qs[QDIV_LAT-1].apply) begin
                n_vel[l] = r_qs[QDIV_LAT-1].vel[l];
            end else if (s > 36'sd2147483647) begin
                n_vel[l] = 32'h7fff_ffff;
            end else if (s < -36'sd2147483648) begin
                n_vel[l] = 32'h8000_0000;
            end else begin
                n_vel[l] = s[31:0];
            end
        end
    end

    // Output registers.
    always_ff @(posedge i_clk) begin
        o_a_new_vel_x <= n_vel[0];
        o_a_new_vel_y <= n_vel[1];
        o_b_new_vel_x <= n_vel[2];
        o_b_new_vel_y <= n_vel[3];
        o_collided    <= r_qs[QDIV_LAT-1].apply;
    end

    assign o_valid = r_vld[VLD_LEN-1];

endmodule
